>>> src/qte_pkg.sv
`default_nettype none
package qte_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int QUAT_W      = 16;
  localparam int PROD_W      = 2 * QUAT_W;
  localparam int TERM_W      = 34;        // 2*(a*b + c*d) and 1 - 2*(...) in Q28
  localparam int MAG_W       = 28;        // |s| below one
  localparam int REM_W       = 57;        // 2^56 - s^2
  localparam int ROOT_W      = 29;        // sqrt result, at most 2^28
  localparam int SQRT_STEPS  = 29;        // one result bit per step
  localparam int VEC_W       = 36;        // cordic x/y with gain headroom
  localparam int ANG_W       = 32;        // degrees, Q20
  localparam int ACC_FRAC    = 20;
  localparam int TABLE_LEN   = 24;
  localparam int FIFO_DEPTH  = 2;

  localparam int PITCH_W = 16;
  localparam int ROLL_W  = 18;
  localparam int YAW_W   = 17;

  typedef struct packed {
    logic signed [TERM_W-1:0] roll_y;
    logic signed [TERM_W-1:0] roll_x;
    logic signed [TERM_W-1:0] pitch_s;
    logic signed [TERM_W-1:0] yaw_y;
    logic signed [TERM_W-1:0] yaw_x;
    logic [REM_W-1:0]         rem;
    logic                     clamp;
  } qte_terms_t;

  // atan(2^-idx) in degrees, Q20
  function automatic logic signed [ANG_W-1:0] atan_q20(input int unsigned idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 32'sd47185920;
      1:  v = 32'sd27855475;
      2:  v = 32'sd14718068;
      3:  v = 32'sd7471121;
      4:  v = 32'sd3750058;
      5:  v = 32'sd1876857;
      6:  v = 32'sd938658;
      7:  v = 32'sd469357;
      8:  v = 32'sd234682;
      9:  v = 32'sd117342;
      10: v = 32'sd58671;
      11: v = 32'sd29335;
      12: v = 32'sd14668;
      13: v = 32'sd7334;
      14: v = 32'sd3667;
      15: v = 32'sd1833;
      16: v = 32'sd917;
      17: v = 32'sd458;
      18: v = 32'sd229;
      19: v = 32'sd115;
      20: v = 32'sd57;
      21: v = 32'sd29;
      22: v = 32'sd14;
      23: v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/qte_if.sv
`default_nettype none
interface qte_in_if;
  logic        valid;
  logic        ready;
  logic signed [qte_pkg::QUAT_W-1:0] quat_i;
  logic signed [qte_pkg::QUAT_W-1:0] quat_j;
  logic signed [qte_pkg::QUAT_W-1:0] quat_k;
  logic signed [qte_pkg::QUAT_W-1:0] quat_real;
  modport source (output valid, output quat_i, output quat_j, output quat_k,
                  output quat_real, input ready);
  modport sink   (input valid, input quat_i, input quat_j, input quat_k,
                  input quat_real, output ready);
endinterface

interface qte_out_if;
  logic        valid;
  logic        ready;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_angle;
  logic signed [qte_pkg::ROLL_W-1:0]  roll_angle;
  logic [qte_pkg::YAW_W-1:0]          yaw_angle;
  logic                               pitch_clamped;
  modport source (output valid, output pitch_angle, output roll_angle,
                  output yaw_angle, output pitch_clamped, input ready);
  modport sink   (input valid, input pitch_angle, input roll_angle,
                  input yaw_angle, input pitch_clamped, output ready);
endinterface
`default_nettype wire

>>> src/qte_front.sv
`default_nettype none
module qte_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  qte_in_if.sink              in_ch,
  output logic                out_valid,
  input  wire logic           out_ready,
  output qte_pkg::qte_terms_t out_terms
);

  localparam int TW = qte_pkg::TERM_W;
  localparam int PW = qte_pkg::PROD_W;
  localparam int SQW = 2 * qte_pkg::MAG_W;
  localparam logic signed [TW-1:0] ONE_Q28 = TW'(1) <<< 28;

  logic v1_r, v2_r, v3_r;
  logic en;

  // stage 1: component products
  logic signed [qte_pkg::PROD_W-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wy_r;
  logic signed [qte_pkg::PROD_W-1:0] p_zx_r, p_wz_r, p_xy_r, p_zz_r;

  // stage 2: trig terms
  qte_pkg::qte_terms_t       t2_r, t2_nxt;
  logic [qte_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic signed [TW-1:0]      s_abs;

  // stage 3: cosine radicand
  qte_pkg::qte_terms_t       t3_r, t3_nxt;
  logic [2*qte_pkg::MAG_W-1:0] mag_sq;

  assign en          = !v3_r || out_ready;
  assign in_ch.ready = en;
  assign out_valid   = v3_r;
  assign out_terms   = t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= PW'(in_ch.quat_real) * PW'(in_ch.quat_i);
      p_yz_r <= PW'(in_ch.quat_j) * PW'(in_ch.quat_k);
      p_xx_r <= PW'(in_ch.quat_i) * PW'(in_ch.quat_i);
      p_yy_r <= PW'(in_ch.quat_j) * PW'(in_ch.quat_j);
      p_wy_r <= PW'(in_ch.quat_real) * PW'(in_ch.quat_j);
      p_zx_r <= PW'(in_ch.quat_k) * PW'(in_ch.quat_i);
      p_wz_r <= PW'(in_ch.quat_real) * PW'(in_ch.quat_k);
      p_xy_r <= PW'(in_ch.quat_i) * PW'(in_ch.quat_j);
      p_zz_r <= PW'(in_ch.quat_k) * PW'(in_ch.quat_k);
    end
  end

  always_comb begin
    t2_nxt         = '0;
    t2_nxt.roll_y  = (TW'(p_wx_r) + TW'(p_yz_r)) <<< 1;
    t2_nxt.roll_x  = ONE_Q28 - ((TW'(p_xx_r) + TW'(p_yy_r)) <<< 1);
    t2_nxt.pitch_s = (TW'(p_wy_r) - TW'(p_zx_r)) <<< 1;
    t2_nxt.yaw_y   = (TW'(p_wz_r) + TW'(p_xy_r)) <<< 1;
    t2_nxt.yaw_x   = ONE_Q28 - ((TW'(p_yy_r) + TW'(p_zz_r)) <<< 1);
    t2_nxt.clamp   = (t2_nxt.pitch_s >= ONE_Q28) || (t2_nxt.pitch_s <= -ONE_Q28);
    s_abs          = t2_nxt.pitch_s[TW-1] ? -t2_nxt.pitch_s : t2_nxt.pitch_s;
    mag_nxt        = s_abs[qte_pkg::MAG_W-1:0];
  end

  assign mag_sq = SQW'(mag_r) * SQW'(mag_r);

  always_comb begin
    t3_nxt     = t2_r;
    // meaningless when clamped, pitch then ignores the cordic
    t3_nxt.rem = (qte_pkg::REM_W'(1) << 56) - qte_pkg::REM_W'(mag_sq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r  <= t2_nxt;
      mag_r <= mag_nxt;
      t3_r  <= t3_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/qte_fifo.sv
`default_nettype none
module qte_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire qte_pkg::qte_terms_t push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output qte_pkg::qte_terms_t pop_data
);

  localparam int DEPTH = qte_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qte_pkg::qte_terms_t mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic push, pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> src/qte_cordic.sv
`default_nettype none
module qte_cordic #(
  parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [qte_pkg::VEC_W-1:0]   y_in,
  input  wire logic signed [qte_pkg::VEC_W-1:0]   x_in,
  output logic signed [qte_pkg::ANG_W-1:0]        z_out
);

  localparam int VW = qte_pkg::VEC_W;
  localparam int AW = qte_pkg::ANG_W;
  localparam logic signed [AW-1:0] DEG180 = AW'(180) <<< qte_pkg::ACC_FRAC;

  logic signed [VW-1:0] x_r [0:STAGES];
  logic signed [VW-1:0] y_r [0:STAGES];
  logic signed [AW-1:0] z_r [0:STAGES];
  logic                 h_r [0:STAGES];

  // pre-rotation into the right half plane; a zero y term settles at once
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x_in;
      y_r[0] <= y_in;
      h_r[0] <= 1'b0;
      z_r[0] <= '0;
      if (y_in == '0) begin
        h_r[0] <= 1'b1;
        z_r[0] <= x_in[VW-1] ? DEG180 : '0;
      end else if (x_in[VW-1]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= (y_in > 0) ? DEG180 : -DEG180;
      end
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN_K = qte_pkg::atan_q20(k);
    always_ff @(posedge clk) begin
      if (en) begin
        h_r[k+1] <= h_r[k];
        if (h_r[k]) begin
          x_r[k+1] <= x_r[k];
          y_r[k+1] <= y_r[k];
          z_r[k+1] <= z_r[k];
        end else if (y_r[k] > 0) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ATAN_K;
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ATAN_K;
        end
      end
    end
  end

  assign z_out = z_r[STAGES];

endmodule
`default_nettype wire

>>> src/qte_back.sv
`default_nettype none
module qte_back #(
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire qte_pkg::qte_terms_t in_terms,
  qte_out_if.source                out_ch
);

  localparam int NS = (CORDIC_STAGES > qte_pkg::TABLE_LEN) ? qte_pkg::TABLE_LEN
                                                           : CORDIC_STAGES;
  localparam int SQ = qte_pkg::SQRT_STEPS;
  localparam int CL = NS + 1;
  localparam int RW = qte_pkg::REM_W;
  localparam int VW = qte_pkg::VEC_W;
  localparam int AW = qte_pkg::ANG_W;
  localparam int SH = qte_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] HALF    = AW'(1) <<< (SH - 1);
  localparam logic signed [AW-1:0] UNIT90  = AW'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] UNIT360 = AW'(360) <<< ANGLE_FRAC_BITS;

  logic en;

  // square root chain
  logic                sv_r [0:SQ];
  qte_pkg::qte_terms_t st_r [0:SQ];
  logic [RW:0]         rs_r [0:SQ];
  logic [qte_pkg::ROOT_W-1:0] root;

  // cordic section side lines
  logic cv_r [0:CL-1];
  logic cc_r [0:CL-1];
  logic cp_r [0:CL-1];
  logic signed [AW-1:0] z_roll, z_pitch, z_yaw;
  logic signed [AW-1:0] r_roll, r_pitch, r_yaw, yaw_tmp, yaw_fix, pitch_fix;

  logic ov_r;
  logic signed [qte_pkg::PITCH_W-1:0] pitch_r;
  logic signed [qte_pkg::ROLL_W-1:0]  roll_r;
  logic [qte_pkg::YAW_W-1:0]          yaw_r;
  logic                               clamp_r;

  assign en       = !ov_r || out_ch.ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= in_terms;
      rs_r[0] <= '0;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [RW:0] BIT_C = (RW + 1)'(1) << (2 * (SQ - 1 - k));
    logic [RW:0] trial;
    logic        take;
    qte_pkg::qte_terms_t st_nxt;
    assign trial = rs_r[k] + BIT_C;
    assign take  = {1'b0, st_r[k].rem} >= trial;
    always_comb begin
      st_nxt = st_r[k];
      if (take) begin
        st_nxt.rem = st_r[k].rem - trial[RW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= st_nxt;
        if (take) begin
          rs_r[k+1] <= (rs_r[k] >> 1) + BIT_C;
        end else begin
          rs_r[k+1] <= rs_r[k] >> 1;
        end
      end
    end
  end

  assign root = rs_r[SQ][qte_pkg::ROOT_W-1:0];

  qte_cordic #(.STAGES(NS)) u_roll (
    .clk(clk), .en(en),
    .y_in(VW'(st_r[SQ].roll_y)), .x_in(VW'(st_r[SQ].roll_x)), .z_out(z_roll)
  );

  qte_cordic #(.STAGES(NS)) u_pitch (
    .clk(clk), .en(en),
    .y_in(VW'(st_r[SQ].pitch_s)), .x_in(VW'($signed({1'b0, root}))), .z_out(z_pitch)
  );

  qte_cordic #(.STAGES(NS)) u_yaw (
    .clk(clk), .en(en),
    .y_in(VW'(st_r[SQ].yaw_y)), .x_in(VW'(st_r[SQ].yaw_x)), .z_out(z_yaw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r[0] <= st_r[SQ].clamp;
      cp_r[0] <= st_r[SQ].pitch_s > 0;
      for (int j = 1; j < CL; j++) begin
        cc_r[j] <= cc_r[j-1];
        cp_r[j] <= cp_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= SQ; j++) sv_r[j] <= 1'b0;
      for (int j = 0; j < CL; j++)  cv_r[j] <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      sv_r[0] <= in_valid;
      for (int j = 1; j <= SQ; j++) sv_r[j] <= sv_r[j-1];
      cv_r[0] <= sv_r[SQ];
      for (int j = 1; j < CL; j++)  cv_r[j] <= cv_r[j-1];
      ov_r <= cv_r[CL-1];
    end
  end

  // round to output precision, ties up, then fixed offsets
  always_comb begin
    r_roll    = (z_roll  + HALF) >>> SH;
    r_pitch   = (z_pitch + HALF) >>> SH;
    r_yaw     = (z_yaw   + HALF) >>> SH;
    yaw_tmp   = -r_yaw - UNIT90;
    yaw_fix   = yaw_tmp[AW-1] ? yaw_tmp + UNIT360 : yaw_tmp;
    pitch_fix = cc_r[CL-1] ? (cp_r[CL-1] ? UNIT90 : -UNIT90) : r_pitch;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_r <= pitch_fix[qte_pkg::PITCH_W-1:0];
      roll_r  <= qte_pkg::ROLL_W'(UNIT90 - r_roll);
      yaw_r   <= yaw_fix[qte_pkg::YAW_W-1:0];
      clamp_r <= cc_r[CL-1];
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.pitch_angle   = pitch_r;
  assign out_ch.roll_angle    = roll_r;
  assign out_ch.yaw_angle     = yaw_r;
  assign out_ch.pitch_clamped = clamp_r;

endmodule
`default_nettype wire

>>> src/quaternion_to_euler_angles.sv
// quaternion to remapped z-y-x euler angles, fully pipelined
// in_ch takes one quaternion request (quat_i, quat_j, quat_k, quat_real, signed q14)
// out_ch returns pitch, roll and yaw in degrees with ANGLE_FRAC_BITS fraction
// bits plus a flag set when the pitch sine reached magnitude one and was clamped
// throughput: one request per cycle, sustained while out_ch.ready stays high
// the pitch cosine comes from a 29-step square-root chain ahead of the cordic stages
// front: products, trig terms and cosine radicand over three stages
// a two-entry queue sits between front and back so each stalls on its own
// back: square-root chain, three cordic vectoring pipes, rounding and offsets
// when out_ch.ready is low the back pipe holds, the queue fills, then the front
// holds and in_ch.ready drops; nothing is lost or repeated
// reset (rst_n low, synchronous) clears all valid bits; no requests are in flight
// afterwards and in_ch.ready is high on the first cycle out of reset
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  localparam int AW = qte_pkg::ANG_W;
  localparam logic signed [AW-1:0] UNIT90  = AW'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] UNIT270 = AW'(270) <<< ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] UNIT360 = AW'(360) <<< ANGLE_FRAC_BITS;

  // front to queue
  logic                f_valid, f_ready;
  qte_pkg::qte_terms_t f_terms;

  // queue to back
  logic                q_valid, q_ready;
  qte_pkg::qte_terms_t q_terms;

  qte_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .out_valid(f_valid), .out_ready(f_ready), .out_terms(f_terms)
  );

  qte_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_terms),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_terms)
  );

  qte_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .in_valid(q_valid), .in_ready(q_ready), .in_terms(q_terms),
    .out_ch(out_ch)
  );

  // clamped pitch is exactly plus or minus 90 degrees
  a_clamp_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pitch_clamped |->
      AW'(out_ch.pitch_angle) == UNIT90 || AW'(out_ch.pitch_angle) == -UNIT90)
    else $error("clamped pitch not at a pole");

  // every valid pitch, clamped or not, stays within the poles
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      AW'(out_ch.pitch_angle) <= UNIT90 && AW'(out_ch.pitch_angle) >= -UNIT90)
    else $error("pitch out of range");

  // remapped heading wraps below a full turn
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> AW'(out_ch.yaw_angle) < UNIT360)
    else $error("yaw not wrapped");

  // roll offset keeps it within -90 to 270
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      AW'(out_ch.roll_angle) <= UNIT270 && AW'(out_ch.roll_angle) >= -UNIT90)
    else $error("roll out of range");

endmodule
`default_nettype wire
